// File: rtl/core/flia_pkg.sv
`default_nettype none

package flia_pkg;

  localparam int unsigned ID_W   = 10;
  localparam int unsigned LINK_W = 11;
  localparam int unsigned CAP_W  = 11;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [2:0] {
    ST_FAIL     = 3'd0,
    ST_REUSED   = 3'd1,
    ST_FRESH    = 3'd2,
    ST_RECYCLED = 3'd3,
    ST_REJECTED = 3'd4
  } status_t;

  typedef enum logic {
    FUNC_GET     = 1'b0,
    FUNC_RECYCLE = 1'b1
  } func_t;

  // controller to datapath
  typedef struct packed {
    logic clr;     // zero one store entry
    logic accept;  // latch request, read link of head
    logic commit;  // update head/store, load result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;  // clearing pass on its final entry
    logic out_busy;  // result register full and not taken this cycle
  } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/flia_if.sv
`default_nettype none

// request channel
interface flia_req_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [flia_pkg::ID_W-1:0]   recycle_id;

  modport source (output valid, output func, output recycle_id, input ready);
  modport sink   (input valid, input func, input recycle_id, output ready);
endinterface

// result channel
interface flia_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic [flia_pkg::ID_W-1:0]   granted_id;

  modport source (output valid, output status, output granted_id, input ready);
  modport sink   (input valid, input status, input granted_id, output ready);
endinterface

`default_nettype wire

// File: rtl/core/flia_ctrl.sv
`default_nettype none

module flia_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire flia_pkg::dp_sts_t sts,
  output flia_pkg::dp_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r, ready_nxt;

  always_comb begin
    cmd        = '0;
    cmd.clr    = (state_r == S_CLEAR);
    cmd.accept = (state_r == S_IDLE) && in_valid && ready_r;
    cmd.commit = (state_r == S_EXEC) && !sts.out_busy;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
    ready_nxt = (state_nxt == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
    end
  end

  assign in_ready = ready_r;

endmodule

`default_nettype wire

// File: rtl/core/flia_dp.sv
`default_nettype none

module flia_dp #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire flia_pkg::dp_cmd_t                 cmd,
  output flia_pkg::dp_sts_t                      sts,
  input  wire logic                              in_func,
  input  wire logic [flia_pkg::ID_W-1:0]         in_recycle_id,
  input  wire logic                              cfg_we,
  input  wire logic [flia_pkg::CAP_W-1:0]        cfg_wdata,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [2:0]                             out_status,
  output logic [flia_pkg::ID_W-1:0]              out_granted_id
);

  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);

  // entry 0 is kept in head_r; the memory copy of entry 0 stays zero
  logic [flia_pkg::LINK_W-1:0] link_mem [STORE_DEPTH];

  logic [AW-1:0]                 clr_addr_r;
  logic [flia_pkg::LINK_W-1:0]   head_r;
  logic [flia_pkg::CAP_W-1:0]    cap_r;
  logic                          func_r;
  logic [flia_pkg::ID_W-1:0]     rid_r;
  logic [flia_pkg::LINK_W-1:0]   rd_data_r;
  logic                          out_valid_r;
  flia_pkg::status_t             out_status_r;
  logic [flia_pkg::ID_W-1:0]     out_id_r;

  logic [flia_pkg::CAP_W-1:0]    cap_eff;
  logic                          get_fail;
  logic                          rid_ok;
  flia_pkg::status_t             res_status;
  logic [flia_pkg::ID_W-1:0]     res_id;
  logic [flia_pkg::LINK_W-1:0]   head_nxt;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [flia_pkg::LINK_W-1:0]   mem_wdata;

  // capacity in use is clipped to the store depth
  always_comb begin
    if (32'(cap_r) > STORE_DEPTH) cap_eff = flia_pkg::CAP_W'(STORE_DEPTH);
    else                          cap_eff = cap_r;
  end

  assign get_fail = (cap_eff == '0) || (head_r >= cap_eff);
  assign rid_ok   = (32'(rid_r) < STORE_DEPTH);

  always_comb begin
    res_status = flia_pkg::ST_FAIL;
    res_id     = '0;
    head_nxt   = head_r;
    mem_we     = 1'b0;
    mem_waddr  = clr_addr_r;
    mem_wdata  = '0;
    if (func_r == flia_pkg::FUNC_GET) begin
      if (!get_fail) begin
        res_id = head_r[flia_pkg::ID_W-1:0];
        if (rd_data_r != '0) begin
          res_status = flia_pkg::ST_REUSED;
          head_nxt   = rd_data_r;
        end else begin
          res_status = flia_pkg::ST_FRESH;
          head_nxt   = head_r + 1'b1;
        end
      end
    end else begin
      if (rid_ok) begin
        res_status = flia_pkg::ST_RECYCLED;
        head_nxt   = flia_pkg::LINK_W'(rid_r);
        // old head links behind the returned id
        mem_we     = cmd.commit && (rid_r != '0);
        mem_waddr  = AW'(rid_r);
        mem_wdata  = head_r;
      end else begin
        res_status = flia_pkg::ST_REJECTED;
      end
    end
    if (cmd.clr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
    if (cmd.accept) rd_data_r <= link_mem[AW'(head_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      head_r      <= '0;
      cap_r       <= flia_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_addr_r <= clr_addr_r + 1'b1;
      if (cfg_we) cap_r <= cfg_wdata;
      if (cmd.commit) head_r <= head_nxt;
      if (cmd.commit)     out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= in_func;
      rid_r  <= in_recycle_id;
    end
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_id_r     <= res_id;
    end
  end

  always_comb begin
    sts          = '0;
    sts.clr_last = (clr_addr_r == LAST_ADDR);
    sts.out_busy = out_valid_r && !out_ready;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_granted_id = out_id_r;

endmodule

`default_nettype wire

// File: rtl/core/free_list_id_allocator_top.sv
// flow: an accept latches the request and registers the head's link from the
//   store; the commit then updates head/store and loads the result register,
//   stalling while it is full and untaken; no new request until the commit
// reset: synchronous, active low; afterwards a clearing pass zeroes all
//   STORE_DEPTH store entries with in_ch.ready low; capacity resets to 1024
`default_nettype none

module free_list_id_allocator_top #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  flia_req_if.sink                         in_ch,
  flia_rsp_if.source                       out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [flia_pkg::CAP_W-1:0]  cfg_wdata
);

  // command and status between sequencer and datapath
  flia_pkg::dp_cmd_t cmd;
  flia_pkg::dp_sts_t sts;

  // sequencer: clearing pass, then idle -> exec per request
  flia_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: head register, link store, capacity, result register
  flia_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_ch.func),
    .in_recycle_id  (in_ch.recycle_id),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_status     (out_ch.status),
    .out_granted_id (out_ch.granted_id)
  );

  // only one request in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while another is in flight");

  // no request taken right after reset, when the store clearing begins
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ch.ready)
    else $error("ready high right after reset");

  // only a successful get hands out a nonzero id
  a_id_only_on_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == flia_pkg::ST_FAIL
                      || out_ch.status == flia_pkg::ST_RECYCLED
                      || out_ch.status == flia_pkg::ST_REJECTED))
    |-> (out_ch.granted_id == '0))
    else $error("nonzero id on a result that grants nothing");

  // a new result only appears the cycle after the datapath commits a request
  a_result_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !$past(out_ch.valid && !out_ch.ready)) |->
    $past(cmd.commit))
    else $error("result without a completed request");

endmodule

`default_nettype wire
